// ----- src/tpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_pkg
// Types, constants and the CRC-8 step shared by the telemetry frame builder.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int          LOOP_BUDGET_MS_DEF = 10;
  localparam int          QUEUE_DEPTH_DEF    = 2;
  localparam int          CPU_LOAD_MAX       = 9990;
  localparam int          FRAME_LEN          = 27;
  localparam int          PAYLOAD_LEN        = 23;
  localparam int          LEN_POS            = 2;
  localparam logic [15:0] PERIOD_RESET       = 16'd100;
  localparam logic [7:0]  SYNC0              = 8'hAA;
  localparam logic [7:0]  SYNC1              = 8'h55;
  localparam logic [7:0]  PKT_TYPE           = 8'h00;
  localparam logic [7:0]  CRC_POLY           = 8'h8C;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [15:0] temp_left;
    logic signed [15:0] temp_right;
    logic signed [15:0] volt_tenths;
    logic [63:0]        currents_packed;
    logic signed [15:0] pwm_left;
    logic signed [15:0] pwm_right;
    logic [31:0]        loop_time_us;
    logic [7:0]         fault_code;
    logic [15:0]        free_ram;
  } sample_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } result_t;

  // Payload of one frame as it waits in the queue
  typedef struct packed {
    logic [15:0] free_ram;
    logic [7:0]  fault_code;
    logic [15:0] cpu_load;
    logic [15:0] pwm_right;
    logic [15:0] pwm_left;
    logic [15:0] cur_max;
    logic [15:0] volt_tenths;
    logic [15:0] temp_right;
    logic [15:0] temp_left;
    logic [31:0] time_ms;
    logic [7:0]  seq;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] crc_advance(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- src/telemetry_packet_framer_crc8_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_packet_framer_crc8_top
// Rate-limited telemetry framer: sync, length, payload and CRC-8 per sample.
// ----------------------------------------------------------------------------
//   channel | signals                      | moves
//   in      | in_valid, in_stall, in_word  | one sample word
//   out     | out_valid, out_stall, out_word | one frame byte word
//   cfg     | cfg_we, cfg_wdata            | send period in ms
//
// A sample is taken every cycle unless the input stalls; a sent one becomes
// 27 output words, one per cycle unless the output stalls, from the byte
// serializer and its CRC register. Samples inside the period make no words.
// Reset sets the period to 100 and clears time, sequence and queue.
// Output stall holds the serializer; input stalls while a built payload
// waits on a full queue.
// ----------------------------------------------------------------------------
module telemetry_packet_framer_crc8_top #(
  parameter int LOOP_BUDGET_MS = tpf_pkg::LOOP_BUDGET_MS_DEF,
  parameter int QUEUE_DEPTH    = tpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tpf_pkg::sample_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output tpf_pkg::result_t out_word,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);
  import tpf_pkg::*;

  q_status_t q_stat;
  logic      push;
  logic      pop;
  frame_t    push_data;
  frame_t    head;

  tpf_front #(
    .LOOP_BUDGET_MS(LOOP_BUDGET_MS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  tpf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  tpf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_last_not_repeated: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_word.last_byte |=> !out_valid || !out_word.last_byte)
    else $error("two frame ends in a row");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_stat.full)
    else $error("input stalled with queue space");

endmodule

// ----- src/tpf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_front
// Takes samples, applies the send period, builds the frame payload.
// ----------------------------------------------------------------------------
module tpf_front #(
  parameter int LOOP_BUDGET_MS = tpf_pkg::LOOP_BUDGET_MS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tpf_pkg::sample_t  in_word,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  tpf_pkg::q_status_t q_stat,
  output logic              push,
  output tpf_pkg::frame_t   push_data
);
  import tpf_pkg::*;

  localparam int          CLAMP_AT = (CPU_LOAD_MAX + 1) * LOOP_BUDGET_MS;
  localparam int          X_W      = $clog2(CLAMP_AT);
  localparam int          L_W      = $clog2(LOOP_BUDGET_MS);
  localparam int          SHIFT    = X_W + L_W;
  localparam int          M_W      = X_W + 1;
  localparam int          PROD_W   = X_W + M_W;
  localparam logic [63:0] MUL_FULL = ((64'd1 << SHIFT) + 64'(LOOP_BUDGET_MS) - 64'd1)
                                     / 64'(LOOP_BUDGET_MS);
  localparam logic [M_W-1:0] MUL   = MUL_FULL[M_W-1:0];

  logic [15:0]       period;
  logic [31:0]       last_sent_time;
  logic [7:0]        seq;
  logic              send;
  logic              accept;

  logic              s1_valid;
  sample_t           s1_word;
  logic [7:0]        s1_seq;
  logic              s1_clamp;
  logic [PROD_W-1:0] s1_prod;

  logic [31:0]       elapsed;
  logic [15:0]       cur [4];
  logic [15:0]       cur_max;
  logic [15:0]       cpu_load;

  assign elapsed  = in_word.time_ms - last_sent_time;
  assign send     = elapsed >= {16'd0, period};
  assign in_stall = s1_valid && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = s1_valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      period         <= PERIOD_RESET;
      last_sent_time <= '0;
      seq            <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        period <= cfg_wdata;
      end
      if (accept && send) begin
        last_sent_time <= in_word.time_ms;
        seq            <= seq + 8'd1;
        s1_valid       <= 1'b1;
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && send) begin
      s1_word  <= in_word;
      s1_seq   <= seq;
      s1_clamp <= in_word.loop_time_us >= 32'(CLAMP_AT);
      s1_prod  <= PROD_W'(in_word.loop_time_us[X_W-1:0]) * PROD_W'(MUL);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cur[k] = s1_word.currents_packed[16*k +: 16];
    end
    cur_max = cur[0];
    for (int k = 1; k < 4; k++) begin
      if ($signed(cur[k]) > $signed(cur_max)) begin
        cur_max = cur[k];
      end
    end
    cpu_load = s1_clamp ? 16'(CPU_LOAD_MAX) : 16'(s1_prod >> SHIFT);
  end

  always_comb begin
    push_data.seq         = s1_seq;
    push_data.time_ms     = s1_word.time_ms;
    push_data.temp_left   = s1_word.temp_left;
    push_data.temp_right  = s1_word.temp_right;
    push_data.volt_tenths = s1_word.volt_tenths;
    push_data.cur_max     = cur_max;
    push_data.pwm_left    = s1_word.pwm_left;
    push_data.pwm_right   = s1_word.pwm_right;
    push_data.cpu_load    = cpu_load;
    push_data.fault_code  = s1_word.fault_code;
    push_data.free_ram    = s1_word.free_ram;
  end

endmodule

// ----- src/tpf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_queue
// Short register queue of frame payloads between front and back.
// ----------------------------------------------------------------------------
module tpf_queue #(
  parameter int DEPTH = tpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tpf_pkg::frame_t    push_data,
  input  logic               pop,
  output tpf_pkg::frame_t    head,
  output tpf_pkg::q_status_t q_stat
);
  import tpf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             entry [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign q_stat.full  = count == CNT_W'(DEPTH);
  assign q_stat.empty = count == '0;
  assign head         = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/tpf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpf_back
// Serializes one queued frame a byte per unstalled cycle, appends the CRC-8.
// ----------------------------------------------------------------------------
module tpf_back (
  input  logic               clk,
  input  logic               rst,
  input  tpf_pkg::frame_t    head,
  input  tpf_pkg::q_status_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tpf_pkg::result_t   out_word
);
  import tpf_pkg::*;

  localparam int IDX_W    = $clog2(FRAME_LEN);
  localparam int LAST_POS = FRAME_LEN - 1;

  logic [IDX_W-1:0]          idx;
  logic [7:0]                crc;
  logic [8*(FRAME_LEN-1)-1:0] frame_bytes;
  logic [7:0]                cur_byte;
  logic                      is_last;
  logic                      load;

  assign frame_bytes = {head.free_ram, head.fault_code, head.cpu_load, head.pwm_right,
                        head.pwm_left, head.cur_max, head.volt_tenths, head.temp_right,
                        head.temp_left, head.time_ms, PKT_TYPE, head.seq,
                        8'(PAYLOAD_LEN), SYNC1, SYNC0};

  assign is_last  = idx == IDX_W'(LAST_POS);
  assign cur_byte = is_last ? crc : frame_bytes[{idx, 3'b000} +: 8];
  assign load     = !q_stat.empty && (!out_valid || !out_stall);
  assign pop      = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      crc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + 1'b1;
        if (idx == IDX_W'(LEN_POS)) begin
          crc <= crc_advance(8'd0, cur_byte);
        end else if (idx > IDX_W'(LEN_POS) && !is_last) begin
          crc <= crc_advance(crc, cur_byte);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word.frame_byte <= cur_byte;
      out_word.last_byte  <= is_last;
    end
  end

endmodule

// ----- dv/telemetry_packet_framer_crc8_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_packet_framer_crc8_top_tb
// Self-checking bench for the rate-limited telemetry framer.
// A table of directed samples covers the send window edges, time wrap, the
// zero and maximum periods, the current maximum and CPU load clamping. Random
// phases with varied sender gaps and receiver stalls follow. Every frame byte
// is predicted in the bench and compared in order against the output words.
// ----------------------------------------------------------------------------
module telemetry_packet_framer_crc8_top_tb;
  import tpf_pkg::*;

  localparam int          BUDGET_MS   = 10;
  localparam logic [31:0] LOAD_CAP    = 32'd9990;
  localparam logic [7:0]  SYNC_A      = 8'hAA;
  localparam logic [7:0]  SYNC_B      = 8'h55;
  localparam logic [7:0]  BODY_LEN    = 8'd23;
  localparam logic [7:0]  POLY_REFL   = 8'h8C;
  localparam int          SETTLE      = 40;

  typedef enum logic {CHK_SENT, CHK_DROP} chk_e;
  typedef enum logic [1:0] {FILL_LOW, FILL_HIGH, FILL_MIX} fill_e;

  typedef struct {
    bit          wr;
    logic [15:0] per;
    chk_e        chk;
    fill_e       fill;
    logic [31:0] t;
    logic [63:0] cur;
    logic [31:0] loop;
  } row_t;

  typedef struct {
    int          idle;
    int          stall;
    logic [15:0] per;
    int          items;
  } phase_t;

  row_t plan [19] = '{
    '{1'b0, 16'd0,     CHK_DROP, FILL_MIX,  32'h0000_0000, 64'h0000_0000_0000_0000, 32'd0},
    '{1'b0, 16'd0,     CHK_DROP, FILL_HIGH, 32'h0000_0063, 64'h0001_0002_0003_0004, 32'd5000},
    '{1'b0, 16'd0,     CHK_SENT, FILL_LOW,  32'h0000_0064, 64'h8000_8000_8000_8000, 32'd0},
    '{1'b0, 16'd0,     CHK_DROP, FILL_MIX,  32'h0000_00C7, 64'h0000_0000_0000_0000, 32'd1},
    '{1'b0, 16'd0,     CHK_SENT, FILL_HIGH, 32'h0000_00C8, 64'h7FFF_0000_8000_0001, 32'hFFFF_FFFF},
    '{1'b0, 16'd0,     CHK_SENT, FILL_MIX,  32'hFFFF_FFFF, 64'h8000_7FFF_8000_8000, 32'd99900},
    '{1'b0, 16'd0,     CHK_DROP, FILL_MIX,  32'h0000_0010, 64'h0000_0000_0000_0000, 32'd0},
    '{1'b0, 16'd0,     CHK_SENT, FILL_LOW,  32'h0000_0063, 64'h8001_8000_7FFF_FFFF, 32'd99909},
    '{1'b1, 16'd0,     CHK_SENT, FILL_MIX,  32'h0000_0063, 64'h8000_8000_8000_7FFF, 32'd99910},
    '{1'b0, 16'd0,     CHK_SENT, FILL_LOW,  32'h0000_0063, 64'hFFFF_FFFF_FFFF_FFFF, 32'd99899},
    '{1'b0, 16'd0,     CHK_SENT, FILL_MIX,  32'h0000_0000, 64'hFFFE_FFFF_FFFD_FFFC, 32'd9},
    '{1'b1, 16'd1,     CHK_DROP, FILL_MIX,  32'h0000_0000, 64'h0000_0000_0000_0000, 32'd0},
    '{1'b0, 16'd0,     CHK_SENT, FILL_MIX,  32'h0000_0001, 64'h0010_0020_0030_0040, 32'd10},
    '{1'b1, 16'hFFFF,  CHK_DROP, FILL_MIX,  32'h0000_FFFF, 64'h0000_0000_0000_0000, 32'd0},
    '{1'b0, 16'd0,     CHK_SENT, FILL_HIGH, 32'h0001_0000, 64'h1234_5678_9ABC_DEF0, 32'd11},
    '{1'b0, 16'd0,     CHK_DROP, FILL_MIX,  32'h0001_FFFE, 64'h0000_0000_0000_0000, 32'd0},
    '{1'b0, 16'd0,     CHK_SENT, FILL_HIGH, 32'hFFFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 32'd20},
    '{1'b1, 16'd100,   CHK_DROP, FILL_MIX,  32'h0000_0062, 64'h0000_0000_0000_0000, 32'd0},
    '{1'b0, 16'd0,     CHK_SENT, FILL_MIX,  32'h0000_0063, 64'hA5A5_5A5A_0FF0_F00F, 32'd42}
  };

  phase_t phases [5] = '{
    '{0,  0,  16'd0,    20},
    '{54, 0,  16'd7,    25},
    '{0,  54, 16'hFFFF, 25},
    '{13, 13, 16'd0,    20},
    '{13, 13, 16'd250,  25}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  sample_t     in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_word;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  result_t     frame_due [$];
  result_t     want_word;
  logic [31:0] last_tx_ms = 32'd0;
  logic [7:0]  seq_next   = 8'd0;
  logic [15:0] period_cfg = 16'd100;
  int          bad_words    = 0;
  int          idle_pct     = 0;
  int          stall_pct    = 0;

  telemetry_packet_framer_crc8_top #(.LOOP_BUDGET_MS(BUDGET_MS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) r = {1'b0, r[7:1]} ^ (r[0] ? POLY_REFL : 8'h00);
    return r;
  endfunction

  // Queues the 27 frame bytes of a sample if its send window is open.
  function automatic bit build_frame(input sample_t s);
    logic [8*23-1:0] body;
    logic [15:0]     peak;
    logic [15:0]     ch;
    logic [31:0]     load;
    logic [7:0]      crc;
    if (s.time_ms - last_tx_ms < {16'd0, period_cfg}) return 1'b0;
    last_tx_ms = s.time_ms;
    peak = s.currents_packed[15:0];
    for (int c = 1; c < 4; c++) begin
      ch = s.currents_packed[16*c +: 16];
      if ($signed(ch) > $signed(peak)) peak = ch;
    end
    load = s.loop_time_us / BUDGET_MS;
    if (load > LOAD_CAP) load = LOAD_CAP;
    body = {s.free_ram, s.fault_code, load[15:0], s.pwm_right, s.pwm_left, peak,
            s.volt_tenths, s.temp_right, s.temp_left, s.time_ms, 8'h00, seq_next};
    seq_next++;
    frame_due.push_back('{SYNC_A, 1'b0});
    frame_due.push_back('{SYNC_B, 1'b0});
    frame_due.push_back('{BODY_LEN, 1'b0});
    crc = crc_step(8'h00, BODY_LEN);
    for (int k = 0; k < 23; k++) begin
      frame_due.push_back('{body[8*k +: 8], 1'b0});
      crc = crc_step(crc, body[8*k +: 8]);
    end
    frame_due.push_back('{crc, 1'b1});
    return 1'b1;
  endfunction

  task automatic push_sample(input sample_t s, input bit hold, output bit sent);
    @(negedge clk);
    while ((hold && frame_due.size() != 0) || $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= s;
    do @(posedge clk); while (in_stall);
    sent = build_frame(s);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_period(input logic [15:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    period_cfg  = v;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (frame_due.size() == 0) begin
        bad_words++;
        $display("%0t: unexpected word byte=%h last=%b", $time,
                 out_word.frame_byte, out_word.last_byte);
      end else begin
        want_word = frame_due.pop_front();
        if (out_word.frame_byte !== want_word.frame_byte) begin
          bad_words++;
          $display("%0t: frame_byte expected %h got %h", $time,
                   want_word.frame_byte, out_word.frame_byte);
        end
        if (out_word.last_byte !== want_word.last_byte) begin
          bad_words++;
          $display("%0t: last_byte expected %b got %b", $time,
                   want_word.last_byte, out_word.last_byte);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    sample_t smp;
    bit      sent;
    int      k;
    int      pick;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].wr) set_period(plan[i].per);
      case (plan[i].fill)
        FILL_LOW: begin
          smp = '{32'd0, 16'sh8000, 16'sh8000, 16'sh8000, 64'd0, 16'sh8000, 16'sh8000,
                  32'd0, 8'h00, 16'h0000};
        end
        FILL_HIGH: begin
          smp = '{32'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 64'd0, 16'sh7FFF, 16'sh7FFF,
                  32'd0, 8'hFF, 16'hFFFF};
        end
        default: begin
          smp = '{32'd0, 16'sd25, -16'sd40, 16'sd124, 64'd0, 16'sd1000, -16'sd1000,
                  32'd0, 8'h03, 16'd1234};
        end
      endcase
      smp.time_ms         = plan[i].t;
      smp.currents_packed = plan[i].cur;
      smp.loop_time_us    = plan[i].loop;
      push_sample(smp, 1'b0, sent);
      if (sent != (plan[i].chk == CHK_SENT)) begin
        bad_words++;
        $display("%0t: sample %0d expected %s got %s", $time, i,
                 plan[i].chk == CHK_SENT ? "frame" : "no frame", sent ? "frame" : "no frame");
      end
    end

    foreach (phases[p]) begin
      set_period(phases[p].per);
      idle_pct  = phases[p].idle;
      stall_pct = phases[p].stall;
      k = 0;
      while (k < phases[p].items) begin
        pick = $urandom_range(99);
        if (pick < 10) smp.time_ms = $urandom();
        else if (pick < 30) smp.time_ms = last_tx_ms + $urandom_range(period_cfg);
        else smp.time_ms = last_tx_ms + period_cfg + $urandom_range(4) - 2;
        smp.temp_left   = 16'($urandom());
        smp.temp_right  = 16'($urandom());
        smp.volt_tenths = 16'($urandom());
        smp.pwm_left    = 16'($urandom());
        smp.pwm_right   = 16'($urandom());
        if ($urandom_range(3) == 0) begin
          for (int c = 0; c < 4; c++)
            smp.currents_packed[16*c +: 16] = 16'($urandom_range(40)) - 16'd20;
        end else begin
          smp.currents_packed = {$urandom(), $urandom()};
        end
        smp.loop_time_us = ($urandom_range(2) == 0) ? $urandom() : $urandom_range(120000);
        smp.fault_code   = 8'($urandom());
        smp.free_ram     = 16'($urandom());
        push_sample(smp, k % 16 == 15, sent);
        k++;
      end
    end

    drain();
    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/tpf_pkg.sv
src/tpf_front.sv
src/tpf_queue.sv
src/tpf_back.sv
src/telemetry_packet_framer_crc8_top.sv
dv/telemetry_packet_framer_crc8_top_tb.sv
